// ----- design/u8u16_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned StatW  = 3;
  localparam int unsigned HeldN  = 3;
  localparam int unsigned CountW = 2;
  localparam int unsigned LenW   = 3;

  localparam logic [UnitW-1:0] ReplResetVal = 16'hFFFD;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_PENDING    = 3'd1,
    ST_PAIR       = 3'd2,
    ST_BAD        = 3'd3,
    ST_BAD_TAIL   = 3'd4,
    ST_DOUBLE_BAD = 3'd5
  } status_e;

  // Sequence lengths named by the lead byte
  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThr  = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  typedef struct packed {
    status_e          status;
    logic [UnitW-1:0] unit_first;
    logic [UnitW-1:0] unit_second;
    logic             pair_valid;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0]          count;
    logic [LenW-1:0]            exp_len;
    logic [HeldN-1:0][ByteW-1:0] held;
  } seq_state_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [LenW-1:0]   exp_len;
    logic              held_we;
    logic [CountW-1:0] held_idx;
    logic [ByteW-1:0]  held_data;
  } state_upd_t;

endpackage

// ----- design/utf8_to_utf16_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// UTF-8 byte stream in, one status plus up to two UTF-16 units out per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one UTF-8 byte per beat on byte_in_i, taken at a rising
//   edge with in_valid_i high and in_stall_o low.
//   Output channel: one result beat per input byte (status, unit_first,
//   unit_second, pair_valid), taken with out_valid_o high and out_stall_i low.
//   Configuration: cfg_we_i writes cfg_data_i into the replacement code unit;
//   write only while no byte is in flight.
//   Path: input register, then decode into the result register.
//   Throughput: one byte per cycle while out_stall_i is low; the next byte
//   depends on open-sequence state, updated in the same cycle as the result.
//   Reset: no sequence open, no beats held, replacement unit = U+FFFD.
//   Stall: a stalled result holds; the input register still takes a beat while
//   it is empty or the result moves on the same edge, else in_stall_o rises.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] unit_first_o,
  output logic [15:0] unit_second_o,
  output logic        pair_valid_o
);
  import u8u16_pkg::*;

  logic [UnitW-1:0] repl_q;
  logic             s1_vld_q;
  logic [ByteW-1:0] byte_q;
  logic             out_vld_q;
  result_t          res_q, res_d;
  seq_state_t       seq_state;
  state_upd_t       seq_upd;
  logic             out_adv, step_en;

  // Replacement code unit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplResetVal;
    end else if (cfg_we_i) begin
      repl_q <= cfg_data_i;
    end
  end

  // The result register frees when empty or taken this edge
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign step_en    = s1_vld_q && out_adv;
  assign in_stall_o = s1_vld_q && !out_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_in_i;
    end
  end

  u8u16_decode u_decode (
    .byte_i   (byte_q),
    .repl_i   (repl_q),
    .state_i  (seq_state),
    .result_o (res_d),
    .upd_o    (seq_upd)
  );

  // Sequence state advances exactly when a byte moves into the result register
  u8u16_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (step_en),
    .upd_i   (seq_upd),
    .state_o (seq_state)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = res_q.status;
  assign unit_first_o  = res_q.unit_first;
  assign unit_second_o = res_q.unit_second;
  assign pair_valid_o  = res_q.pair_valid;

endmodule

// ----- design/u8u16_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_state
// Open-sequence state: byte count, expected length and held bytes.
// ----------------------------------------------------------------------------
module u8u16_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  u8u16_pkg::state_upd_t upd_i,
  output u8u16_pkg::seq_state_t state_o
);
  import u8u16_pkg::*;

  logic [CountW-1:0]           count_q;
  logic [LenW-1:0]             exp_len_q;
  logic [HeldN-1:0][ByteW-1:0] held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      exp_len_q <= LenNone;
    end else if (en_i) begin
      count_q   <= upd_i.count;
      exp_len_q <= upd_i.exp_len;
    end
  end

  // held bytes: no reset, only entries of the open sequence are read
  always_ff @(posedge clk_i) begin
    if (en_i && upd_i.held_we) begin
      held_q[upd_i.held_idx] <= upd_i.held_data;
    end
  end

  assign state_o.count   = count_q;
  assign state_o.exp_len = exp_len_q;
  assign state_o.held    = held_q;

endmodule

// ----- design/u8u16_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte decode: classifies the byte, builds the result and next state.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic [7:0]            byte_i,
  input  logic [15:0]           repl_i,
  input  u8u16_pkg::seq_state_t state_i,
  output u8u16_pkg::result_t    result_o,
  output u8u16_pkg::state_upd_t upd_o
);
  import u8u16_pkg::*;

  logic              is_ascii, is_cont, faulted;
  logic [CountW-1:0] eff_count;
  logic [LenW-1:0]   lead_len, eff_len, count_inc;
  logic [ByteW-1:0]  lead, h1, h2;
  logic [10:0]       cp2;
  logic [15:0]       cp3;
  logic [20:0]       cp4, v4;
  logic              ok2, ok3, ok4;
  result_t           full_res;

  always_comb begin
    case (byte_i) inside
      8'b110?_????: lead_len = LenTwo;
      8'b1110_????: lead_len = LenThr;
      8'b1111_0???: lead_len = LenFour;
      default:      lead_len = LenNone;
    endcase
  end

  assign is_ascii  = ~byte_i[7];
  assign is_cont   = (byte_i[7:6] == 2'b10);
  assign faulted   = (state_i.count != '0) && !is_cont && !is_ascii;
  assign eff_count = faulted ? '0 : state_i.count;
  assign eff_len   = (eff_count == '0) ? lead_len : state_i.exp_len;
  assign count_inc = {1'b0, eff_count} + 3'd1;

  // Completed-sequence decode, strict
  assign lead = state_i.held[0];
  assign h1   = state_i.held[1];
  assign h2   = state_i.held[2];
  assign cp2  = {lead[4:0], byte_i[5:0]};
  assign cp3  = {lead[3:0], h1[5:0], byte_i[5:0]};
  assign cp4  = {lead[2:0], h1[5:0], h2[5:0], byte_i[5:0]};
  assign v4   = cp4 - 21'h10000;
  assign ok2  = (lead[4:1] != 4'd0);
  assign ok3  = (cp3 >= 16'h0800) && (cp3[15:11] != 5'b11011);
  assign ok4  = (cp4 >= 21'h10000) && (cp4 <= 21'h10FFFF);

  always_comb begin
    full_res = '{status: ST_BAD, unit_first: repl_i, unit_second: '0, pair_valid: 1'b0};
    case (state_i.exp_len)
      LenTwo: begin
        if (ok2) full_res = '{ST_OK, {5'd0, cp2}, 16'd0, 1'b0};
      end
      LenThr: begin
        if (ok3) full_res = '{ST_OK, cp3, 16'd0, 1'b0};
      end
      default: begin
        if (ok4) full_res = '{ST_PAIR, {6'b110110, v4[19:10]}, {6'b110111, v4[9:0]}, 1'b1};
      end
    endcase
  end

  always_comb begin
    result_o = '{status: ST_BAD, unit_first: repl_i, unit_second: '0, pair_valid: 1'b0};
    upd_o    = '{count: '0, exp_len: state_i.exp_len, held_we: 1'b0,
                 held_idx: eff_count, held_data: byte_i};
    if (is_ascii) begin
      if (state_i.count != '0) begin
        result_o = '{ST_BAD_TAIL, repl_i, {8'd0, byte_i}, 1'b1};
      end else begin
        result_o = '{ST_OK, {8'd0, byte_i}, 16'd0, 1'b0};
      end
    end else if (eff_count == '0 && lead_len == LenNone) begin
      // invalid lead; a fault on the same byte doubles the replacement
      if (faulted) result_o = '{ST_DOUBLE_BAD, repl_i, repl_i, 1'b1};
    end else if (count_inc < eff_len) begin
      upd_o.count   = count_inc[CountW-1:0];
      upd_o.exp_len = eff_len;
      upd_o.held_we = 1'b1;
      result_o.status = faulted ? ST_BAD : ST_PENDING;
    end else begin
      result_o = full_res;
    end
  end

endmodule
